// File: rtl/hrl_pkg.sv
package hrl_pkg;

   // parser phase within a record
   typedef enum logic [2:0] {
      PH_WAIT,
      PH_COUNT,
      PH_OFFSET,
      PH_TYPE,
      PH_DATA,
      PH_PAYLOAD,
      PH_CHECK,
      PH_STOP
   } phase_type;

   // result kind codes
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_FMT  = 2'd2,
      KIND_SUM  = 2'd3
   } kind_type;

   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // record type codes
   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;
   localparam logic [7:0] REC_SEG  = 8'h02;
   localparam logic [7:0] REC_EXT  = 8'h04;

   // fixed field sizes in bytes
   localparam logic [7:0] WORD_BYTES = 8'd2;

   typedef struct packed {
      logic       is_hex;
      logic       is_space;
      logic       is_colon;
      logic [3:0] nibble;
   } char_class_type;

   typedef struct packed {
      logic        hit;
      kind_type    kind;
      logic [31:0] address;
      logic [7:0]  data_byte;
   } result_type;

endpackage

// File: rtl/hrl_channels.sv
interface hrl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface hrl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] address;
   logic [7:0]  data_byte;

   modport source (output valid, output kind, output address, output data_byte, input ready);
   modport sink (input valid, input kind, input address, input data_byte, output ready);
endinterface

// File: rtl/hrl_char_class.sv
module hrl_char_class
   import hrl_pkg::*;
(
   input  logic [7:0]     char_code,
   output char_class_type char_class
);

   always_comb begin
      char_class.is_space = char_code inside {8'h20, [8'h09:8'h0D]};
      char_class.is_colon = (char_code == CHAR_COLON);
      char_class.is_hex   = 1'b1;
      char_class.nibble   = 4'd0;
      if (char_code inside {[8'h30:8'h39]}) begin
         char_class.nibble = 4'(char_code - 8'h30);
      end else if (char_code inside {[8'h41:8'h46]}) begin
         char_class.nibble = 4'(char_code - 8'h37);
      end else if (char_code inside {[8'h61:8'h66]}) begin
         char_class.nibble = 4'(char_code - 8'h57);
      end else begin
         char_class.is_hex = 1'b0;
      end
   end

endmodule

// File: rtl/hrl_parser.sv
module hrl_parser
   import hrl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  char_class_type char_class,
   output result_type     result
);

   phase_type   phase_ff, phase_in;
   logic        pending_ff, pending_in;
   logic [3:0]  high_ff, high_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  rec_kind_ff, rec_kind_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] upper_ff, upper_in;
   logic [15:0] payload_ff, payload_in;

   logic [7:0]  full_byte;
   logic [7:0]  sum_next;
   logic [8:0]  index_next;
   logic [31:0] data_address;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         pending_ff  <= 1'b0;
         high_ff     <= '0;
         length_ff   <= '0;
         offset_ff   <= '0;
         rec_kind_ff <= '0;
         index_ff    <= '0;
         sum_ff      <= '0;
         upper_ff    <= '0;
         payload_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         pending_ff  <= pending_in;
         high_ff     <= high_in;
         length_ff   <= length_in;
         offset_ff   <= offset_in;
         rec_kind_ff <= rec_kind_in;
         index_ff    <= index_in;
         sum_ff      <= sum_in;
         upper_ff    <= upper_in;
         payload_ff  <= payload_in;
      end
   end

   assign full_byte    = {high_ff, char_class.nibble};
   assign sum_next     = sum_ff + full_byte;
   assign index_next   = {1'b0, index_ff} + 9'd1;
   assign data_address = {upper_ff, 16'd0} + {16'd0, offset_ff} + {24'd0, index_ff};

   always_comb begin
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      high_in     = high_ff;
      length_in   = length_ff;
      offset_in   = offset_ff;
      rec_kind_in = rec_kind_ff;
      index_in    = index_ff;
      sum_in      = sum_ff;
      upper_in    = upper_ff;
      payload_in  = payload_ff;
      result      = '{hit: 1'b0, kind: KIND_DATA, address: 32'd0, data_byte: 8'd0};

      if (step) begin
         case (phase_ff)
            PH_STOP: begin
            end
            PH_WAIT: begin
               if (char_class.is_colon) begin
                  phase_in    = PH_COUNT;
                  pending_in  = 1'b0;
                  high_in     = '0;
                  length_in   = '0;
                  offset_in   = '0;
                  rec_kind_in = '0;
                  index_in    = '0;
                  sum_in      = '0;
                  payload_in  = '0;
               end else if (!char_class.is_space) begin
                  phase_in    = PH_STOP;
                  result.hit  = 1'b1;
                  result.kind = KIND_FMT;
               end
            end
            default: begin
               if (!char_class.is_hex) begin
                  phase_in    = PH_STOP;
                  result.hit  = 1'b1;
                  result.kind = KIND_FMT;
               end else if (!pending_ff) begin
                  high_in    = char_class.nibble;
                  pending_in = 1'b1;
               end else begin
                  pending_in = 1'b0;
                  sum_in     = sum_next;
                  case (phase_ff)
                     PH_COUNT: begin
                        length_in = full_byte;
                        index_in  = '0;
                        phase_in  = PH_OFFSET;
                     end
                     PH_OFFSET: begin
                        offset_in = {offset_ff[7:0], full_byte};
                        index_in  = index_next[7:0];
                        if (index_next >= {1'b0, WORD_BYTES}) begin
                           index_in = '0;
                           phase_in = PH_TYPE;
                        end
                     end
                     PH_TYPE: begin
                        rec_kind_in = full_byte;
                        index_in    = '0;
                        if (full_byte == REC_DATA) begin
                           phase_in = (length_ff != 8'd0) ? PH_DATA : PH_CHECK;
                        end else if (full_byte == REC_EOF) begin
                           if (length_ff != 8'd0) begin
                              phase_in    = PH_STOP;
                              result.hit  = 1'b1;
                              result.kind = KIND_FMT;
                           end else begin
                              phase_in = PH_CHECK;
                           end
                        end else if (full_byte == REC_SEG || full_byte == REC_EXT) begin
                           if (length_ff != WORD_BYTES) begin
                              phase_in    = PH_STOP;
                              result.hit  = 1'b1;
                              result.kind = KIND_FMT;
                           end else begin
                              payload_in = '0;
                              phase_in   = PH_PAYLOAD;
                           end
                        end else begin
                           phase_in    = PH_STOP;
                           result.hit  = 1'b1;
                           result.kind = KIND_FMT;
                        end
                     end
                     PH_DATA: begin
                        index_in = index_next[7:0];
                        if (index_next >= {1'b0, length_ff}) begin
                           phase_in = PH_CHECK;
                        end
                        result.hit       = 1'b1;
                        result.kind      = KIND_DATA;
                        result.address   = data_address;
                        result.data_byte = full_byte;
                     end
                     PH_PAYLOAD: begin
                        payload_in = {payload_ff[7:0], full_byte};
                        index_in   = index_next[7:0];
                        if (index_next >= {1'b0, WORD_BYTES}) begin
                           if (rec_kind_ff == REC_EXT) begin
                              upper_in = {payload_ff[7:0], full_byte};
                           end
                           phase_in = PH_CHECK;
                        end
                     end
                     PH_CHECK: begin
                        if (sum_next != 8'd0) begin
                           phase_in    = PH_STOP;
                           result.hit  = 1'b1;
                           result.kind = KIND_SUM;
                        end else if (rec_kind_ff == REC_EOF) begin
                           phase_in    = PH_STOP;
                           result.hit  = 1'b1;
                           result.kind = KIND_END;
                        end else begin
                           phase_in = PH_WAIT;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         endcase
      end
   end

`ifndef SYNTH
   // once stopped, the parser never leaves the stop phase
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STOP |=> phase_ff == PH_STOP)
      else $error("parser left stop phase");

   // a stopped parser never reports anything
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STOP |-> !result.hit)
      else $error("result after stop");

   // a data byte only comes out while in the data phase with a full byte
   assert property (@(posedge clock) disable iff (reset)
      result.hit && result.kind == KIND_DATA |-> phase_ff == PH_DATA && pending_ff)
      else $error("data byte outside data phase");
`endif

endmodule

// File: rtl/hex_record_loader.sv
// hex_record_loader: streaming parser for hex records in ASCII text
//
// req_chan carries one character per transaction (valid/ready). rsp_chan
// carries zero or one result per character: a data byte with its 32-bit
// address, an end-of-file marker, a format error or a checksum error.
// whitespace between records is skipped, ':' opens a record, hex digits
// may be either case. type 4 records load the upper address half.
//
// a character is captured in the input register and parsed there by the
// record state machine, which only steps when the output register has room;
// its result is then loaded into the output register, which drives rsp
// valid and the result fields.
// throughput: one character per cycle while the output register is not
// blocked; characters that produce no result pass through at that rate too.
//
// stall: while a result waits in the output register and rsp ready is low,
// one more character is held in the input register, then req ready drops.
// reset clears both registers and the parser; after an end record or an
// error the block consumes further characters silently until reset.
module hex_record_loader
   import hrl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hrl_req_if.sink   req_chan,
   hrl_rsp_if.source rsp_chan
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;

   // output stage
   logic        out_valid_ff, out_valid_in;
   kind_type    out_kind_ff, out_kind_in;
   logic [31:0] out_address_ff, out_address_in;
   logic [7:0]  out_data_ff, out_data_in;

   logic           advance;
   logic           step;
   char_class_type char_class;
   result_type     result;

   // output slot free or being drained this cycle
   assign advance = !out_valid_ff || rsp_chan.ready;
   // parser consumes the held character only when its result has room
   assign step = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   hrl_char_class u_class (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   hrl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .char_class (char_class),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_char_in  = req_chan.char_code;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_kind_in    = out_kind_ff;
      out_address_in = out_address_ff;
      out_data_in    = out_data_ff;
      if (advance) begin
         // a new result (or an empty slot) replaces the drained one
         out_valid_in   = step && result.hit;
         out_kind_in    = result.kind;
         out_address_in = result.address;
         out_data_in    = result.data_byte;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_char_ff     <= in_char_in;
      out_kind_ff    <= out_kind_in;
      out_address_ff <= out_address_in;
      out_data_ff    <= out_data_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kind      = out_kind_ff;
   assign rsp_chan.address   = out_address_ff;
   assign rsp_chan.data_byte = out_data_ff;

`ifndef SYNTH
   // a held character stays put while the output slot is blocked
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("held character lost or changed");

   // every parser result lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      step && result.hit |=> out_valid_ff)
      else $error("parser result dropped");

   // after a terminal result is taken, nothing further is reported
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_chan.ready && out_kind_ff != KIND_DATA |=> !out_valid_ff)
      else $error("result after end or error");

   // an empty output slot never blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_chan.ready)
      else $error("input stalled with empty output");
`endif

endmodule

// File: bench/tb_hex_record_loader.sv
module tb_hex_record_loader;
   timeunit 1ns;
   timeprecision 1ps;

   import hrl_pkg::*;

   // ascii codes used to build and decode the text stream
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // letter case of generated hex digits
   localparam int CASE_MIXED = 0;
   localparam int CASE_UPPER = 1;
   localparam int CASE_LOWER = 2;

   // characters sent in all before the random part stops adding records
   localparam int RANDOM_CHARS = 1550;
   // cycles with no transaction on either channel before giving up
   localparam int STALL_LIMIT  = 2000;

   // ways the one and only terminating event of the run can happen
   typedef enum int {
      STOP_END,
      STOP_BAD_SUM,
      STOP_JUNK,
      STOP_BAD_DIGIT,
      STOP_BAD_TYPE,
      STOP_BAD_COUNT
   } stop_cause_type;

   // one result of the loader
   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [7:0]  data_byte;
   } load_event_type;

   logic clock;
   logic reset;

   hrl_req_if req_if ();
   hrl_rsp_if rsp_if ();

   hex_record_loader u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // record parser state mirrored in the bench; reset happens once only,
   // so the declared values are the post-reset state
   // ------------------------------------------------------------------
   phase_type   parse_phase  = PH_WAIT;
   logic        nibble_held  = 1'b0;
   logic [3:0]  held_nibble  = 4'h0;
   logic [7:0]  rec_len      = 8'h00;
   logic [15:0] rec_offset   = 16'h0000;
   logic [7:0]  rec_type     = 8'h00;
   logic [7:0]  byte_count   = 8'h00;
   logic [7:0]  running_sum  = 8'h00;
   logic [15:0] upper_half   = 16'h0000;
   logic [15:0] payload_word = 16'h0000;

   // results the loader still owes, oldest first
   load_event_type loader_outcomes[$];

   // payload bytes of the record about to be sent
   logic [7:0]  record_payload[$];

   int   mismatch_count = 0;
   int   idle_cycles    = 0;
   int   chars_sent     = 0;
   int   digit_case     = CASE_MIXED;
   int   stall_left     = 0;
   bit   quiet_tail     = 1'b0;
   logic took_any;
   load_event_type oldest;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // bit 4 set means the character is no hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, c[3:0]};
      if ((c >= CH_UPPER_A && c <= CH_UPPER_F) || (c >= CH_LOWER_A && c <= CH_LOWER_F))
         return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
   endfunction

   function automatic void post_outcome(input kind_type k, input logic [31:0] a,
                                        input logic [7:0] d);
      load_event_type ev;
      ev.kind      = k;
      ev.address   = a;
      ev.data_byte = d;
      loader_outcomes.push_back(ev);
   endfunction

   // error: report once, then the parser goes silent for good
   function automatic void halt_with(input kind_type k);
      parse_phase = PH_STOP;
      post_outcome(k, 32'h0, 8'h00);
   endfunction

   // advance the parser by one accepted character
   function automatic void parse_char(input logic [7:0] c);
      logic [4:0]  digit;
      logic [7:0]  b;
      logic [31:0] addr;
      if (parse_phase == PH_STOP) return;
      if (parse_phase == PH_WAIT) begin
         if (is_blank(c)) return;
         if (c != CHAR_COLON) begin
            halt_with(KIND_FMT);
            return;
         end
         parse_phase  = PH_COUNT;
         nibble_held  = 1'b0;
         held_nibble  = 4'h0;
         rec_len      = 8'h00;
         rec_offset   = 16'h0000;
         rec_type     = 8'h00;
         byte_count   = 8'h00;
         running_sum  = 8'h00;
         payload_word = 16'h0000;
         return;
      end
      digit = hex_nibble(c);
      if (digit[4]) begin
         halt_with(KIND_FMT);
         return;
      end
      if (!nibble_held) begin
         held_nibble = digit[3:0];
         nibble_held = 1'b1;
         return;
      end
      nibble_held = 1'b0;
      b = {held_nibble, digit[3:0]};
      running_sum = running_sum + b;
      case (parse_phase)
         PH_COUNT: begin
            rec_len     = b;
            byte_count  = 8'h00;
            parse_phase = PH_OFFSET;
         end
         PH_OFFSET: begin
            rec_offset = {rec_offset[7:0], b};
            byte_count = byte_count + 8'd1;
            if (byte_count >= WORD_BYTES) begin
               byte_count  = 8'h00;
               parse_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            rec_type   = b;
            byte_count = 8'h00;
            if (b == REC_DATA) begin
               parse_phase = (rec_len != 8'h00) ? PH_DATA : PH_CHECK;
            end else if (b == REC_EOF) begin
               if (rec_len != 8'h00) halt_with(KIND_FMT);
               else parse_phase = PH_CHECK;
            end else if (b == REC_SEG || b == REC_EXT) begin
               if (rec_len != WORD_BYTES) begin
                  halt_with(KIND_FMT);
               end else begin
                  payload_word = 16'h0000;
                  parse_phase  = PH_PAYLOAD;
               end
            end else begin
               halt_with(KIND_FMT);
            end
         end
         PH_DATA: begin
            // 32-bit sum, so offset plus index carries into the upper half
            addr = {upper_half, 16'h0000} + {16'h0000, rec_offset} + {24'h000000, byte_count};
            byte_count = byte_count + 8'd1;
            if (byte_count >= rec_len) parse_phase = PH_CHECK;
            post_outcome(KIND_DATA, addr, b);
         end
         PH_PAYLOAD: begin
            payload_word = {payload_word[7:0], b};
            byte_count   = byte_count + 8'd1;
            if (byte_count >= WORD_BYTES) begin
               // segment records are summed but never move addresses
               if (rec_type == REC_EXT) upper_half = payload_word;
               parse_phase = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (running_sum != 8'h00) begin
               halt_with(KIND_SUM);
            end else if (rec_type == REC_EOF) begin
               parse_phase = PH_STOP;
               post_outcome(KIND_END, 32'h0, 8'h00);
            end else begin
               parse_phase = PH_WAIT;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch: %s", what);
   endtask

   // ------------------------------------------------------------------
   // monitor: feeds accepted characters to the parser copy and checks
   // each result transaction against the oldest owed outcome
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         took_any = 1'b0;
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            parse_char(req_if.char_code);
            took_any = 1'b1;
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            took_any = 1'b1;
            if (loader_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d addr %h data %h",
                                         rsp_if.kind, rsp_if.address, rsp_if.data_byte));
            end else begin
               oldest = loader_outcomes.pop_front();
               if (rsp_if.kind !== oldest.kind || rsp_if.address !== oldest.address ||
                   rsp_if.data_byte !== oldest.data_byte)
                  report_mismatch($sformatf(
                     "got kind %0d addr %h data %h, want kind %0d addr %h data %h",
                     rsp_if.kind, rsp_if.address, rsp_if.data_byte,
                     oldest.kind, oldest.address, oldest.data_byte));
            end
         end
         // watchdog: cycles with no transaction on either channel
         idle_cycles = took_any ? 0 : idle_cycles + 1;
      end
   end

   // result side back-pressure: random stall bursts, none in the tail
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         stall_left = 0;
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // give up when nothing moves for too long
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // one character transaction, with an occasional idle burst first
   task automatic send_char(input logic [7:0] c);
      if (!quiet_tail && $urandom_range(0, 11) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= c;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      chars_sent++;
   endtask

   function automatic logic [7:0] blank_char(input int idx);
      case (idx)
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return 8'h0A;   // line feed
         3:       return 8'h0B;   // vertical tab
         4:       return 8'h0C;   // form feed
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic lower;
      lower = (digit_case == CASE_LOWER) ||
              (digit_case == CASE_MIXED && $urandom_range(0, 1) == 1);
      if (n < 4'd10) return CH_ZERO + {4'h0, n};
      return (lower ? CH_LOWER_A : CH_UPPER_A) + {4'h0, n} - 8'd10;
   endfunction

   task automatic send_hex(input logic [7:0] b);
      send_char(hex_char(b[7:4]));
      send_char(hex_char(b[3:0]));
   endtask

   task automatic send_blanks(input int most);
      repeat ($urandom_range(0, most)) send_char(blank_char($urandom_range(0, 5)));
   endtask

   // bytes and words lean toward the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'hFFFF - 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic void fill_payload(input int n);
      record_payload.delete();
      repeat (n) record_payload.push_back(pick_byte());
   endfunction

   // one record with the given count field; a nonzero bias spoils the checksum
   task automatic send_record(input logic [7:0] count, input logic [15:0] offset,
                              input logic [7:0] rtype, input logic [7:0] sum_bias);
      logic [7:0] sum;
      logic [7:0] check;
      sum = count + offset[15:8] + offset[7:0] + rtype;
      foreach (record_payload[i]) sum = sum + record_payload[i];
      check = 8'h00 - sum + sum_bias;
      send_char(CHAR_COLON);
      send_hex(count);
      send_hex(offset[15:8]);
      send_hex(offset[7:0]);
      send_hex(rtype);
      foreach (record_payload[i]) send_hex(record_payload[i]);
      send_hex(check);
   endtask

   task automatic send_word_record(input logic [7:0] rtype, input logic [15:0] value);
      record_payload.delete();
      record_payload.push_back(value[15:8]);
      record_payload.push_back(value[7:0]);
      send_record(WORD_BYTES, pick_word(), rtype, 8'h00);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // whitespace kinds, both letter cases, empty data record, address
   // carry and 32-bit wrap, segment record leaving addresses alone
   task automatic test_directed_records();
      for (int i = 0; i < 6; i++) send_char(blank_char(i));
      digit_case = CASE_UPPER;
      record_payload.delete();
      send_record(8'h00, 16'h0000, REC_DATA, 8'h00);
      send_char(CH_CR);
      send_char(8'h0A);
      record_payload.delete();
      record_payload.push_back(8'h00);
      record_payload.push_back(8'hFF);
      send_record(8'h02, 16'hFFFF, REC_DATA, 8'h00);
      digit_case = CASE_LOWER;
      send_word_record(REC_EXT, 16'hFFFF);
      record_payload.delete();
      record_payload.push_back(8'hA5);
      record_payload.push_back(8'h5A);
      record_payload.push_back(8'hFF);
      send_record(8'h03, 16'hFFFF, REC_DATA, 8'h00);
      send_word_record(REC_SEG, 16'h1234);
      record_payload.delete();
      record_payload.push_back(8'hC3);
      send_record(8'h01, 16'h0000, REC_DATA, 8'h00);
      digit_case = CASE_MIXED;
      send_word_record(REC_EXT, 16'h0000);
   endtask

   // well-formed records with random content, mostly short data records
   task automatic test_random_records();
      int pick;
      int len;
      while (chars_sent < RANDOM_CHARS) begin
         send_blanks(3);
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            send_word_record(REC_EXT, pick_word());
         end else if (pick < 5) begin
            send_word_record(REC_SEG, pick_word());
         end else begin
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(17, 255)
                                               : $urandom_range(0, 16);
            fill_payload(len);
            send_record(8'(len), pick_word(), REC_DATA, 8'h00);
         end
      end
   endtask

   // the single terminating event of the run: an end record or one error
   task automatic test_stream_stop();
      stop_cause_type cause;
      logic [7:0]  c;
      logic [7:0]  rtype;
      logic [7:0]  count;
      logic [4:0]  probe;
      send_blanks(2);
      cause = stop_cause_type'($urandom_range(0, 6) % 6);
      if ($urandom_range(0, 6) == 6) cause = STOP_END;
      case (cause)
         STOP_END: begin
            record_payload.delete();
            send_record(8'h00, pick_word(), REC_EOF, 8'h00);
         end
         STOP_BAD_SUM: begin
            // data bytes already out stay valid, the error follows them
            case ($urandom_range(0, 3))
               0: rtype = REC_EOF;
               1: rtype = REC_SEG;
               2: rtype = REC_EXT;
               default: rtype = REC_DATA;
            endcase
            if (rtype == REC_EOF) fill_payload(0);
            else if (rtype == REC_DATA) fill_payload($urandom_range(0, 8));
            else fill_payload(WORD_BYTES);
            send_record(8'(record_payload.size()), pick_word(), rtype,
                        8'($urandom_range(1, 255)));
         end
         STOP_JUNK: begin
            do c = 8'($urandom_range(0, 255)); while (is_blank(c) || c == CHAR_COLON);
            send_char(c);
         end
         STOP_BAD_DIGIT: begin
            send_char(CHAR_COLON);
            repeat ($urandom_range(0, 10)) send_char(hex_char(4'($urandom_range(0, 15))));
            case ($urandom_range(0, 2))
               0: c = blank_char($urandom_range(0, 5));
               1: c = CHAR_COLON;
               default: begin
                  do begin
                     c = 8'($urandom_range(0, 255));
                     probe = hex_nibble(c);
                  end while (!probe[4]);
               end
            endcase
            send_char(c);
         end
         STOP_BAD_TYPE: begin
            do rtype = 8'($urandom_range(0, 255));
            while (rtype == REC_DATA || rtype == REC_EOF || rtype == REC_SEG ||
                   rtype == REC_EXT);
            fill_payload($urandom_range(0, 4));
            send_record(8'(record_payload.size()), pick_word(), rtype, 8'h00);
         end
         default: begin
            // count that does not fit the record type
            case ($urandom_range(0, 2))
               0: rtype = REC_EOF;
               1: rtype = REC_SEG;
               default: rtype = REC_EXT;
            endcase
            if (rtype == REC_EOF) count = 8'($urandom_range(1, 255));
            else do count = 8'($urandom_range(0, 255)); while (count == WORD_BYTES);
            fill_payload((count > 8'd4) ? 4 : int'(count));
            send_record(count, pick_word(), rtype, 8'h00);
         end
      endcase
   endtask

   // once stopped, every further character is swallowed with no result
   task automatic test_input_after_stop();
      repeat (40) send_char(8'($urandom_range(0, 255)));
      fill_payload(4);
      send_record(8'h04, pick_word(), REC_DATA, 8'h00);
      repeat (40) send_char(8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_code = 8'h00;
      rsp_if.ready     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_records();
      test_random_records();
      // no idling on either side from here on
      quiet_tail = 1'b1;
      test_stream_stop();
      test_input_after_stop();
      req_if.valid <= 1'b0;

      // drain what is still owed, then let the pipeline settle
      while (loader_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
